FILE: rtl/pim_request_address_mapper_defines.svh
// ----------------------------------------------------------------------------
// pim_request_address_mapper_defines.svh
// Assertion macros shared by the address mapper RTL.
// ----------------------------------------------------------------------------
`ifndef PIM_REQUEST_ADDRESS_MAPPER_DEFINES_SVH
`define PIM_REQUEST_ADDRESS_MAPPER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define PRAM_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define PRAM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/pram_pkg.sv
// ----------------------------------------------------------------------------
// pram_pkg
// Types, codes and helpers for the PIM request address mapper.
// ----------------------------------------------------------------------------
package pram_pkg;

	// Widths
	localparam int IDX_W      = 16;
	localparam int ADDR_W     = 64;
	localparam int LOG2_W     = 5;
	localparam int OFF_W      = 8;
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 3;

	// Address arithmetic constants
	localparam int ROWS_PER_BLOCK = 32;
	localparam int WORD_COLS      = 16;
	localparam int WRITE_MUL_COLS = 32;
	localparam int RANGE_BIT      = 62;
	localparam int MASK_SHIFT     = 32;

	// Request type codes
	localparam logic [3:0] FUNC_OTHER        = 4'd0;
	localparam logic [3:0] FUNC_SET          = 4'd1;
	localparam logic [3:0] FUNC_NOR          = 4'd2;
	localparam logic [3:0] FUNC_WRITE_SINGLE = 4'd3;
	localparam logic [3:0] FUNC_MV_SINGLE    = 4'd4;
	localparam logic [3:0] FUNC_RD_SINGLE    = 4'd5;
	localparam logic [3:0] FUNC_MUL_RD       = 4'd6;
	localparam logic [3:0] FUNC_WRITE_MUL    = 4'd7;
	localparam logic [3:0] FUNC_RD_ALL       = 4'd8;
	localparam logic [3:0] FUNC_MASK         = 4'd9;

	// Register indexes (byte address = 4 * index)
	localparam logic [REG_IDX_W-1:0] REG_CHANNEL = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_TILE    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PE      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_AG      = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ARRAY   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_ROW     = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_COLUMN  = 3'd6;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [LOG2_W-1:0] log2_t;
	typedef logic [OFF_W-1:0]  off_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// Level sizes as exponents
	typedef struct packed {
		log2_t column_log2;
		log2_t row_log2;
		log2_t array_log2;
		log2_t ag_log2;
		log2_t pe_log2;
		log2_t tile_log2;
		log2_t channel_log2;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		column_log2:  5'd7,
		row_log2:     5'd7,
		array_log2:   5'd3,
		ag_log2:      5'd2,
		pe_log2:      5'd4,
		tile_log2:    5'd4,
		channel_log2: 5'd1
	};

	// Request data word, last field in the low bits
	typedef struct packed {
		logic [6:0] pad;
		idx_t       col_operand;
		idx_t       row_offset;
		logic       block_select_flag;
		idx_t       block_sel;
		idx_t       array_sel;
		idx_t       ag_sel;
		idx_t       pe_sel;
		idx_t       tile_sel;
		idx_t       channel_sel;
		addr_t      bit_address;
	} req_data_t;

	// Request kind
	typedef struct packed {
		logic       decoded_mode;
		logic [3:0] func;
	} req_user_t;

	typedef struct packed {
		req_user_t  user;
		req_data_t  data;
	} req_t;

	// Result word, channel index in the low bits
	typedef struct packed {
		idx_t column_index;
		idx_t row_index;
		idx_t array_index;
		idx_t ag_index;
		idx_t pe_index;
		idx_t tile_index;
		idx_t channel_index;
	} res_t;

	localparam int S_TDATA_W = $bits(req_data_t);
	localparam int S_TUSER_W = $bits(req_user_t);
	localparam int M_TDATA_W = $bits(res_t);

	// Low-bit mask of a level, capped at the index width
	function automatic idx_t level_mask(input log2_t lg);
		idx_t m;
		for (int k = 0; k < IDX_W; k++) begin
			m[k] = (LOG2_W'(k) < lg);
		end
		return m;
	endfunction

	// Field of the address starting at bit off, masked to its level
	function automatic idx_t slice_field(input addr_t addr, input off_t off, input log2_t lg);
		addr_t sh;
		sh = (off >= off_t'(ADDR_W)) ? '0 : (addr >> off[$clog2(ADDR_W)-1:0]);
		return idx_t'(sh) & level_mask(lg);
	endfunction

endpackage

FILE: rtl/pram_regs.sv
// ----------------------------------------------------------------------------
// pram_regs
// APB register file holding the log2 size of each hierarchy level.
// ----------------------------------------------------------------------------
`include "pim_request_address_mapper_defines.svh"

module pram_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pram_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [pram_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [pram_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	output pram_pkg::cfg_t                      cfg
);

	pram_pkg::cfg_t                     cfg_q;
	logic                               wr_en;
	logic [pram_pkg::REG_IDX_W-1:0]     reg_idx;
	pram_pkg::log2_t                    wr_val;
	pram_pkg::log2_t                    rd_val;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[pram_pkg::APB_ADDR_W-1:2];
	assign wr_val  = pwdata[pram_pkg::LOG2_W-1:0];
	assign cfg     = cfg_q;

	// Register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= pram_pkg::CFG_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				pram_pkg::REG_CHANNEL: cfg_q.channel_log2 <= wr_val;
				pram_pkg::REG_TILE:    cfg_q.tile_log2    <= wr_val;
				pram_pkg::REG_PE:      cfg_q.pe_log2      <= wr_val;
				pram_pkg::REG_AG:      cfg_q.ag_log2      <= wr_val;
				pram_pkg::REG_ARRAY:   cfg_q.array_log2   <= wr_val;
				pram_pkg::REG_ROW:     cfg_q.row_log2     <= wr_val;
				pram_pkg::REG_COLUMN:  cfg_q.column_log2  <= wr_val;
				default: begin
				end
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (reg_idx)
			pram_pkg::REG_CHANNEL: rd_val = cfg_q.channel_log2;
			pram_pkg::REG_TILE:    rd_val = cfg_q.tile_log2;
			pram_pkg::REG_PE:      rd_val = cfg_q.pe_log2;
			pram_pkg::REG_AG:      rd_val = cfg_q.ag_log2;
			pram_pkg::REG_ARRAY:   rd_val = cfg_q.array_log2;
			pram_pkg::REG_ROW:     rd_val = cfg_q.row_log2;
			pram_pkg::REG_COLUMN:  rd_val = cfg_q.column_log2;
			default:               rd_val = '0;
		endcase
		prdata = pram_pkg::APB_DATA_W'(rd_val);
	end

	`PRAM_ASSERT_NEXT(a_col_write, wr_en && reg_idx == pram_pkg::REG_COLUMN,
		cfg_q.column_log2 == $past(wr_val), "column_log2 not updated by write")
	`PRAM_ASSERT_NEXT(a_row_write, wr_en && reg_idx == pram_pkg::REG_ROW,
		cfg_q.row_log2 == $past(wr_val), "row_log2 not updated by write")

endmodule

FILE: rtl/pim_request_address_mapper.sv
// ----------------------------------------------------------------------------
// pim_request_address_mapper
// Maps a memory request to channel/tile/pe/ag/array/row/column indices.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_*       in   s_tvalid/s_tready      s_tdata request fields, s_tuser kind
//  m_*       out  m_tvalid/m_tready      m_tdata seven 16-bit indices
//  apb       in   psel/penable/pwrite    level log2 registers, pready tied high
//
//  One request per cycle sustained while m_tready stays high; a request
//  passes the input register, then the mapping logic, then the result register.
//  Reset clears both valid flags and loads the register defaults; there is
//  no clearing pass. A stall on m_tready holds the result register, and the
//  input register still takes a request when the result register empties
//  in the same cycle.
// ----------------------------------------------------------------------------
`include "pim_request_address_mapper_defines.svh"

module pim_request_address_mapper (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pram_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [pram_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [pram_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	// request in
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// bit_address[63:0] channel_sel[79:64] tile_sel[95:80] pe_sel[111:96]
	// ag_sel[127:112] array_sel[143:128] block_sel[159:144]
	// block_select_flag[160] row_offset[176:161] col_operand[192:177] zero pad
	input  logic [pram_pkg::S_TDATA_W-1:0]      s_tdata,
	// func[3:0] decoded_mode[4]
	input  logic [pram_pkg::S_TUSER_W-1:0]      s_tuser,
	// result out
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// channel_index[15:0] tile_index[31:16] pe_index[47:32] ag_index[63:48]
	// array_index[79:64] row_index[95:80] column_index[111:96]
	output logic [pram_pkg::M_TDATA_W-1:0]      m_tdata
);

	pram_pkg::cfg_t   cfg;
	pram_pkg::req_t   req_s1;
	logic             valid_s1;
	pram_pkg::res_t   res_s2;
	logic             valid_s2;
	logic             adv_s2;
	logic             adv_s1;
	pram_pkg::res_t   res_d;

	pram_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// Handshake: result register frees up when taken or empty
	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;
	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1.data <= pram_pkg::req_data_t'(s_tdata);
			req_s1.user <= pram_pkg::req_user_t'(s_tuser);
		end
	end

	// Mapping logic
	always_comb begin
		logic             single;
		logic             range_op;
		logic             mask_op;
		pram_pkg::idx_t   rib;
		pram_pkg::idx_t   col_pos;
		pram_pkg::idx_t   blk_rows;
		pram_pkg::idx_t   row_val;
		pram_pkg::idx_t   col_val;
		pram_pkg::addr_t  addr;
		pram_pkg::off_t   off_row;
		pram_pkg::off_t   off_array;
		pram_pkg::off_t   off_ag;
		pram_pkg::off_t   off_pe;
		pram_pkg::off_t   off_tile;
		pram_pkg::off_t   off_channel;

		single   = (req_s1.user.func == pram_pkg::FUNC_WRITE_SINGLE) ||
		           (req_s1.user.func == pram_pkg::FUNC_MV_SINGLE) ||
		           (req_s1.user.func == pram_pkg::FUNC_RD_SINGLE);
		range_op = (req_s1.user.func == pram_pkg::FUNC_MUL_RD) ||
		           (req_s1.user.func == pram_pkg::FUNC_RD_ALL) ||
		           (req_s1.user.func == pram_pkg::FUNC_WRITE_MUL);
		mask_op  = (req_s1.user.func == pram_pkg::FUNC_MASK) ||
		           (req_s1.user.func == pram_pkg::FUNC_WRITE_MUL);

		// decoded row: block base plus clamped row for single ops, zero without block_select_flag
		rib      = (single && !req_s1.data.row_offset[pram_pkg::IDX_W-1]) ?
		           req_s1.data.row_offset : '0;
		blk_rows = pram_pkg::idx_t'(req_s1.data.block_sel * pram_pkg::ROWS_PER_BLOCK);
		row_val  = req_s1.data.block_select_flag ? (blk_rows + rib) : '0;

		// decoded column by request type
		col_pos  = req_s1.data.col_operand[pram_pkg::IDX_W-1] ? '0 : req_s1.data.col_operand;
		case (req_s1.user.func)
			pram_pkg::FUNC_SET,
			pram_pkg::FUNC_NOR:          col_val = req_s1.data.col_operand;
			pram_pkg::FUNC_WRITE_SINGLE,
			pram_pkg::FUNC_MV_SINGLE,
			pram_pkg::FUNC_RD_SINGLE,
			pram_pkg::FUNC_MUL_RD:       col_val = pram_pkg::idx_t'(col_pos * pram_pkg::WORD_COLS);
			pram_pkg::FUNC_WRITE_MUL:    col_val = pram_pkg::idx_t'(req_s1.data.block_sel *
			                                       pram_pkg::WRITE_MUL_COLS);
			default:                     col_val = '0;
		endcase

		// bit-address preprocessing
		addr = req_s1.data.bit_address;
		if (range_op) begin
			addr[pram_pkg::RANGE_BIT] = 1'b0;
		end
		if (mask_op) begin
			addr = addr >> pram_pkg::MASK_SHIFT;
		end

		// field offsets, column field at bit 0
		off_row     = pram_pkg::off_t'(cfg.column_log2);
		off_array   = off_row   + pram_pkg::off_t'(cfg.row_log2);
		off_ag      = off_array + pram_pkg::off_t'(cfg.array_log2);
		off_pe      = off_ag    + pram_pkg::off_t'(cfg.ag_log2);
		off_tile    = off_pe    + pram_pkg::off_t'(cfg.pe_log2);
		off_channel = off_tile  + pram_pkg::off_t'(cfg.tile_log2);

		if (req_s1.user.decoded_mode) begin
			res_d.channel_index = req_s1.data.channel_sel & pram_pkg::level_mask(cfg.channel_log2);
			res_d.tile_index    = req_s1.data.tile_sel    & pram_pkg::level_mask(cfg.tile_log2);
			res_d.pe_index      = req_s1.data.pe_sel      & pram_pkg::level_mask(cfg.pe_log2);
			res_d.ag_index      = req_s1.data.ag_sel      & pram_pkg::level_mask(cfg.ag_log2);
			res_d.array_index   = req_s1.data.array_sel   & pram_pkg::level_mask(cfg.array_log2);
			res_d.row_index     = row_val & pram_pkg::level_mask(cfg.row_log2);
			res_d.column_index  = col_val & pram_pkg::level_mask(cfg.column_log2);
		end else begin
			res_d.column_index  = pram_pkg::slice_field(addr, '0, cfg.column_log2);
			res_d.row_index     = pram_pkg::slice_field(addr, off_row, cfg.row_log2);
			res_d.array_index   = pram_pkg::slice_field(addr, off_array, cfg.array_log2);
			res_d.ag_index      = pram_pkg::slice_field(addr, off_ag, cfg.ag_log2);
			res_d.pe_index      = pram_pkg::slice_field(addr, off_pe, cfg.pe_log2);
			res_d.tile_index    = pram_pkg::slice_field(addr, off_tile, cfg.tile_log2);
			res_d.channel_index = pram_pkg::slice_field(addr, off_channel, cfg.channel_log2);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_d;
		end
	end

	`PRAM_ASSERT(a_stall_cause, !s_tready, valid_s1 && valid_s2 && !m_tready,
		"input stalled without a blocked result")
	`PRAM_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv_s1, valid_s1 && $stable(req_s1),
		"waiting request lost or changed")
	`PRAM_ASSERT(a_col_range, valid_s2,
		(res_s2.column_index & ~pram_pkg::level_mask(cfg.column_log2)) == '0,
		"column index exceeds column count")

endmodule
